// File: rtl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Shared widths, character codes, result kinds and transaction structs for
// the plain PGM token parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apt_pkg;

  localparam int CH_BITS    = 8;
  localparam int VALUE_BITS = 16;
  localparam int SUM_BITS   = VALUE_BITS + 4;
  localparam int ADDR_BITS  = 20;
  localparam int COUNT_BITS = 21;
  localparam int KIND_BITS  = 3;
  localparam int IDX_BITS   = 2;
  localparam int PROD_BITS  = 2 * VALUE_BITS;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {VALUE_BITS{1'b1}};
  localparam logic [PROD_BITS-1:0]  MAX_PIXELS = PROD_BITS'(1048576);

  localparam logic [CH_BITS-1:0] HASH_CH  = 8'h23;
  localparam logic [CH_BITS-1:0] TAB_CH   = 8'h09;
  localparam logic [CH_BITS-1:0] LF_CH    = 8'h0A;
  localparam logic [CH_BITS-1:0] CR_CH    = 8'h0D;
  localparam logic [CH_BITS-1:0] SPACE_CH = 8'h20;
  localparam logic [CH_BITS-1:0] DIGIT_LO = 8'h30;
  localparam logic [CH_BITS-1:0] DIGIT_HI = 8'h39;

  localparam logic [KIND_BITS-1:0] KIND_WIDTH  = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_HEIGHT = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_MAXVAL = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_DROP   = 3'd4;

  localparam logic [IDX_BITS-1:0] TOK_WIDTH  = 2'd0;
  localparam logic [IDX_BITS-1:0] TOK_HEIGHT = 2'd1;
  localparam logic [IDX_BITS-1:0] TOK_MAXVAL = 2'd2;
  localparam logic [IDX_BITS-1:0] TOK_SAMPLE = 2'd3;

  typedef struct packed {
    logic                  emit;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } token_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [VALUE_BITS-1:0] value;
    logic [ADDR_BITS-1:0]  address;
  } result_t;

endpackage

// File: rtl/apt_if.sv
// ----------------------------------------------------------------------------
// apt_if
// Valid/ready channels: text bytes in, parsed results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apt_in_if;
  logic                         valid;
  logic                         ready;
  logic [apt_pkg::CH_BITS-1:0]  ch;
  logic                         end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface apt_out_if;
  logic                            valid;
  logic                            ready;
  logic [apt_pkg::KIND_BITS-1:0]   kind;
  logic [apt_pkg::VALUE_BITS-1:0]  value;
  logic [apt_pkg::ADDR_BITS-1:0]   address;

  modport source (output valid, output kind, output value, output address, input ready);
  modport sink   (input valid, input kind, input value, input address, output ready);
endinterface

// File: rtl/apt_lexer.sv
// ----------------------------------------------------------------------------
// apt_lexer
// Header-line skip, comment tracking and saturating decimal accumulation.
// Flags a finished token when a delimiter or the end of input closes one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apt_lexer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [apt_pkg::CH_BITS-1:0]  ch,
  input  logic                         eoi,
  output apt_pkg::token_t              tok
);

  logic                           skip_hdr_r, skip_hdr_nxt;
  logic                           in_cmt_r, in_cmt_nxt;
  logic [apt_pkg::VALUE_BITS-1:0] accum_r, accum_nxt;
  logic                           have_digit_r, have_digit_nxt;

  logic                           is_delim, is_hash, is_digit, is_eol;
  logic                           cmt_clear, active, delim_emit;
  logic [apt_pkg::SUM_BITS-1:0]   acc_wide, acc_sum;
  logic [apt_pkg::VALUE_BITS-1:0] accum_a;
  logic                           have_a;

  assign is_eol   = (ch == apt_pkg::CR_CH) || (ch == apt_pkg::LF_CH);
  assign is_delim = is_eol || (ch == apt_pkg::TAB_CH) || (ch == apt_pkg::SPACE_CH);
  assign is_hash  = (ch == apt_pkg::HASH_CH);
  assign is_digit = (ch >= apt_pkg::DIGIT_LO) && (ch <= apt_pkg::DIGIT_HI);

  // the end of line that closes a comment is handled as a delimiter too
  assign cmt_clear = in_cmt_r && is_eol;
  assign active    = !skip_hdr_r && (!in_cmt_r || cmt_clear);

  // accum * 10 + digit
  assign acc_wide = apt_pkg::SUM_BITS'(accum_r);
  assign acc_sum  = (acc_wide << 3) + (acc_wide << 1)
                  + apt_pkg::SUM_BITS'(ch[3:0]);

  always_comb begin
    accum_a = accum_r;
    have_a  = have_digit_r;
    if (active && is_digit) begin
      accum_a = (acc_sum > apt_pkg::SUM_BITS'(apt_pkg::VALUE_MAX)) ?
                apt_pkg::VALUE_MAX : acc_sum[apt_pkg::VALUE_BITS-1:0];
      have_a  = 1'b1;
    end
  end

  assign delim_emit = active && is_delim && have_digit_r;

  assign tok.emit  = delim_emit || (eoi && have_a);
  assign tok.value = accum_a;
  assign tok.last  = eoi;

  always_comb begin
    skip_hdr_nxt   = skip_hdr_r;
    in_cmt_nxt     = in_cmt_r;
    accum_nxt      = accum_r;
    have_digit_nxt = have_digit_r;
    if (fire) begin
      if (eoi) begin
        skip_hdr_nxt   = 1'b1;
        in_cmt_nxt     = 1'b0;
        accum_nxt      = '0;
        have_digit_nxt = 1'b0;
      end else begin
        if (skip_hdr_r && (ch == apt_pkg::LF_CH)) begin
          skip_hdr_nxt = 1'b0;
        end
        if (active && is_hash) begin
          in_cmt_nxt = 1'b1;
        end else if (cmt_clear) begin
          in_cmt_nxt = 1'b0;
        end
        if (delim_emit) begin
          accum_nxt      = '0;
          have_digit_nxt = 1'b0;
        end else begin
          accum_nxt      = accum_a;
          have_digit_nxt = have_a;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_hdr_r   <= 1'b1;
      in_cmt_r     <= 1'b0;
      accum_r      <= '0;
      have_digit_r <= 1'b0;
    end else begin
      skip_hdr_r   <= skip_hdr_nxt;
      in_cmt_r     <= in_cmt_nxt;
      accum_r      <= accum_nxt;
      have_digit_r <= have_digit_nxt;
    end
  end

endmodule

// File: rtl/apt_sample_addr.sv
// ----------------------------------------------------------------------------
// apt_sample_addr
// Token classification (width, height, max value, samples) and flipped
// store address generation with a pixel count limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apt_sample_addr (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  apt_pkg::token_t  tok,
  output apt_pkg::result_t res
);

  logic [apt_pkg::IDX_BITS-1:0]   tok_idx_r, tok_idx_nxt;
  logic [apt_pkg::VALUE_BITS-1:0] width_r, width_nxt;
  logic [apt_pkg::VALUE_BITS-1:0] height_r, height_nxt;
  logic [apt_pkg::VALUE_BITS-1:0] column_r, column_nxt;
  logic [apt_pkg::ADDR_BITS-1:0]  row_base_r, row_base_nxt;
  logic [apt_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [apt_pkg::PROD_BITS-1:0]  area_r;

  logic [apt_pkg::COUNT_BITS-1:0] limit;
  logic                           store;
  logic [apt_pkg::VALUE_BITS:0]   col_inc;
  logic                           wrap;
  logic [apt_pkg::ADDR_BITS-1:0]  width_ext, row_base_init, row_base_dec;

  // width and height settle at least two bytes before the max value token,
  // so the registered product of them is always current
  always_ff @(posedge clk) begin
    area_r <= apt_pkg::PROD_BITS'(width_r) * apt_pkg::PROD_BITS'(height_r);
  end

  assign limit = (area_r > apt_pkg::MAX_PIXELS) ?
                 '0 : area_r[apt_pkg::COUNT_BITS-1:0];
  assign store = count_r < limit;

  assign width_ext     = apt_pkg::ADDR_BITS'(width_r);
  // (height - 1) * width; only used when the image fits the limit
  assign row_base_init = (height_r == '0) ?
                         '0 : area_r[apt_pkg::ADDR_BITS-1:0] - width_ext;
  assign row_base_dec  = (row_base_r >= width_ext) ? row_base_r - width_ext : '0;
  assign col_inc       = {1'b0, column_r} + 1'b1;
  assign wrap          = col_inc >= {1'b0, width_r};

  always_comb begin
    res.value   = tok.value;
    res.address = '0;
    case (tok_idx_r)
      apt_pkg::TOK_WIDTH:  res.kind = apt_pkg::KIND_WIDTH;
      apt_pkg::TOK_HEIGHT: res.kind = apt_pkg::KIND_HEIGHT;
      apt_pkg::TOK_MAXVAL: res.kind = apt_pkg::KIND_MAXVAL;
      default: begin
        if (store) begin
          res.kind    = apt_pkg::KIND_SAMPLE;
          res.address = row_base_r + apt_pkg::ADDR_BITS'(column_r);
        end else begin
          res.kind    = apt_pkg::KIND_DROP;
        end
      end
    endcase
  end

  always_comb begin
    tok_idx_nxt  = tok_idx_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    column_nxt   = column_r;
    row_base_nxt = row_base_r;
    count_nxt    = count_r;
    if (fire && tok.emit) begin
      if (tok_idx_r != apt_pkg::TOK_SAMPLE) begin
        tok_idx_nxt = tok_idx_r + 1'b1;
      end
      case (tok_idx_r)
        apt_pkg::TOK_WIDTH:  width_nxt = tok.value;
        apt_pkg::TOK_HEIGHT: height_nxt = tok.value;
        apt_pkg::TOK_MAXVAL: begin
          column_nxt   = '0;
          count_nxt    = '0;
          row_base_nxt = row_base_init;
        end
        default: begin
          if (store) begin
            count_nxt = count_r + 1'b1;
            if (wrap) begin
              column_nxt   = '0;
              row_base_nxt = row_base_dec;
            end else begin
              column_nxt   = col_inc[apt_pkg::VALUE_BITS-1:0];
            end
          end
        end
      endcase
    end
    if (fire && tok.last) begin
      tok_idx_nxt  = apt_pkg::TOK_WIDTH;
      width_nxt    = '0;
      height_nxt   = '0;
      column_nxt   = '0;
      row_base_nxt = '0;
      count_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_idx_r  <= apt_pkg::TOK_WIDTH;
      width_r    <= '0;
      height_r   <= '0;
      column_r   <= '0;
      row_base_r <= '0;
      count_r    <= '0;
    end else begin
      tok_idx_r  <= tok_idx_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      column_r   <= column_nxt;
      row_base_r <= row_base_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

// File: rtl/ascii_pgm_token_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_pgm_token_parser_core
// Path: a byte passes the input register, then token logic into the output
// register, before its result is valid. Throughput: one byte per cycle,
// bounded by the per-byte accumulate step, while results are not stalled.
// Reset: synchronous active-low rst_n empties both registers and all parse
// state; the header line is skipped again, as after an end-of-input byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascii_pgm_token_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  apt_in_if.sink     in_chan,
  apt_out_if.source  out_chan
);

  logic                         s1_valid_r;
  logic [apt_pkg::CH_BITS-1:0]  ch_r;
  logic                         eoi_r;
  logic                         out_valid_r;
  apt_pkg::result_t             out_r;

  logic                         out_free, advance;
  apt_pkg::token_t              tok;
  apt_pkg::result_t             res;

  assign out_free       = !out_valid_r || out_chan.ready;
  assign advance        = s1_valid_r && out_free;
  assign in_chan.ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      ch_r  <= in_chan.ch;
      eoi_r <= in_chan.end_of_input;
    end
  end

  apt_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .ch    (ch_r),
    .eoi   (eoi_r),
    .tok   (tok)
  );

  apt_sample_addr u_sample_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .tok   (tok),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && tok.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok.emit) begin
      out_r <= res;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.kind    = out_r.kind;
  assign out_chan.value   = out_r.value;
  assign out_chan.address = out_r.address;

endmodule

// File: rtl/apt_checker.sv
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks on the token parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [apt_pkg::KIND_BITS-1:0]   out_kind,
  input logic [apt_pkg::VALUE_BITS-1:0]  out_value,
  input logic [apt_pkg::ADDR_BITS-1:0]   out_address
);

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_value) && $stable(out_address))
    else $error("result changed while stalled");

  // only stored samples carry an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != apt_pkg::KIND_SAMPLE) |-> out_address == '0)
    else $error("nonzero address on a non-sample result");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with nothing held inside, the input side is open
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_valid) && !out_valid |-> in_ready)
    else $error("input stalled while the pipeline is empty");

endmodule

bind ascii_pgm_token_parser_core apt_checker u_apt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_kind    (out_chan.kind),
  .out_value   (out_chan.value),
  .out_address (out_chan.address)
);

// File: tb/sv/apt_pgm_checker.sv
// ----------------------------------------------------------------------------
// apt_pgm_checker
// Watches the byte and result channels of the plain PGM token parser. It
// parses every accepted byte with its own copy of the parse state, queues the
// result that a byte gives, if any, and compares every accepted result
// with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apt_pgm_checker
  import apt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  apt_in_if    in_mon,
  apt_out_if   out_mon,
  output int   mismatch_count,
  output int   results_due
);

  result_t due_results[$];

  logic                  hdr_skip;
  logic                  in_cmt;
  logic                  have_dig;
  int unsigned           token_acc;
  logic [IDX_BITS-1:0]   tok_idx;
  logic [VALUE_BITS-1:0] img_w;
  logic [VALUE_BITS-1:0] img_h;
  logic [VALUE_BITS-1:0] col;
  longint unsigned       row_base;
  longint unsigned       stored;

  function automatic void clear_parse();
    hdr_skip  = 1'b1;
    in_cmt    = 1'b0;
    have_dig  = 1'b0;
    token_acc = 0;
    tok_idx   = TOK_WIDTH;
    img_w     = '0;
    img_h     = '0;
    col       = '0;
    row_base  = 0;
    stored    = 0;
  endfunction

  function automatic void close_token(output result_t res);
    logic [VALUE_BITS-1:0] dim;
    longint unsigned       budget;
    dim         = (token_acc > VALUE_MAX) ? VALUE_MAX : token_acc[VALUE_BITS-1:0];
    res.kind    = KIND_DROP;
    res.value   = token_acc[VALUE_BITS-1:0];
    res.address = '0;
    case (tok_idx)
      TOK_WIDTH: begin
        img_w    = dim;
        res.kind = KIND_WIDTH;
      end
      TOK_HEIGHT: begin
        img_h    = dim;
        res.kind = KIND_HEIGHT;
      end
      TOK_MAXVAL: begin
        res.kind = KIND_MAXVAL;
        col      = '0;
        stored   = 0;
        // bottom row of the flipped image comes first in the file
        row_base = (img_h == 0) ? 0 : (longint'(img_h) - 1) * longint'(img_w);
      end
      default: begin
        budget = longint'(img_w) * longint'(img_h);
        if (budget > MAX_PIXELS) begin
          budget = 0;
        end
        if (stored < budget) begin
          res.kind    = KIND_SAMPLE;
          res.address = ADDR_BITS'(row_base + col);
          stored++;
          col++;
          if (col >= img_w) begin
            col      = '0;
            row_base = (row_base >= img_w) ? row_base - img_w : 0;
          end
        end
      end
    endcase
    if (tok_idx != TOK_SAMPLE) begin
      tok_idx++;
    end
    token_acc = 0;
    have_dig  = 1'b0;
  endfunction

  function automatic bit parse_byte(input logic [CH_BITS-1:0] c, input logic last,
                                    output result_t res);
    bit          got;
    int unsigned nxt;
    got = 1'b0;
    res = '0;
    if (hdr_skip) begin
      if (c == LF_CH) begin
        hdr_skip = 1'b0;
      end
    end else begin
      if (in_cmt && (c == CR_CH || c == LF_CH)) begin
        in_cmt = 1'b0;
      end
      if (!in_cmt) begin
        if (c == TAB_CH || c == CR_CH || c == LF_CH || c == SPACE_CH) begin
          if (have_dig) begin
            close_token(res);
            got = 1'b1;
          end
        end else if (c == HASH_CH) begin
          in_cmt = 1'b1;
        end else if (c >= DIGIT_LO && c <= DIGIT_HI) begin
          nxt       = token_acc * 10 + (c - DIGIT_LO);
          token_acc = (nxt > VALUE_MAX) ? VALUE_MAX : nxt;
          have_dig  = 1'b1;
        end
      end
    end
    // end of input flushes a pending token, then starts a new stream
    if (last) begin
      if (have_dig && !got) begin
        close_token(res);
        got = 1'b1;
      end
      clear_parse();
    end
    return got;
  endfunction

  always @(posedge clk) begin : track
    result_t want;
    result_t fresh;
    if (!rst_n) begin
      clear_parse();
      due_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d value %0d address %0d", $time,
                   out_mon.kind, out_mon.value, out_mon.address);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (out_mon.kind !== want.kind || out_mon.value !== want.value ||
              out_mon.address !== want.address) begin
            mismatch_count++;
            if (out_mon.kind !== want.kind) begin
              $display("%0t: kind mismatch, expected %0d actual %0d", $time,
                       want.kind, out_mon.kind);
            end
            if (out_mon.value !== want.value) begin
              $display("%0t: value mismatch, expected %0d actual %0d", $time,
                       want.value, out_mon.value);
            end
            if (out_mon.address !== want.address) begin
              $display("%0t: address mismatch, expected %0d actual %0d", $time,
                       want.address, out_mon.address);
            end
          end
        end
      end
      // a byte cannot produce its result in the cycle it is taken
      if (in_mon.valid && in_mon.ready &&
          parse_byte(in_mon.ch, in_mon.end_of_input, fresh)) begin
        due_results.push_back(fresh);
      end
    end
    results_due = due_results.size();
  end

endmodule

// File: tb/sv/ascii_pgm_token_parser_core_tb.sv
// ----------------------------------------------------------------------------
// ascii_pgm_token_parser_core_tb
// Feeds the plain PGM token parser with text streams: a short directed part,
// then random streams, mostly well-formed images with random dimensions,
// samples, comments and separators, plus noise and cut-off streams. Both
// channels idle at random; the checker beside the block reports mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascii_pgm_token_parser_core_tb;
  import apt_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  apt_in_if  in_chan ();
  apt_out_if out_chan ();

  int mismatch_count;
  int results_due;

  int snd_idle = 15;
  int rcv_idle = 69;
  int hold_req = 0;
  int body_bytes = 0;

  logic [CH_BITS-1:0] stream_q[$];

  ascii_pgm_token_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  apt_pgm_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  task automatic send_byte(input logic [CH_BITS-1:0] c, input logic last);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.ch           <= c;
    in_chan.end_of_input <= last;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) begin
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    stream_q.delete();
    foreach (s[i]) begin
      stream_q.push_back(s[i]);
    end
    send_stream();
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic void push_byte(input logic [CH_BITS-1:0] b);
    stream_q.push_back(b);
    body_bytes++;
  endfunction

  // '#' and a few random bytes, the closing line end left to the caller
  function automatic void push_comment();
    logic [CH_BITS-1:0] b;
    push_byte(HASH_CH);
    repeat ($urandom_range(0, 6)) begin
      do begin
        b = CH_BITS'($urandom_range(0, 255));
      end while (b == LF_CH || b == CR_CH);
      push_byte(b);
    end
  endfunction

  function automatic void push_sep();
    case ($urandom_range(0, 11))
      6: push_byte(TAB_CH);
      7: push_byte(LF_CH);
      8: begin
        push_byte(CR_CH);
        push_byte(LF_CH);
      end
      9: begin
        push_byte(SPACE_CH);
        push_byte(TAB_CH);
        push_byte(SPACE_CH);
      end
      10: begin
        push_byte(SPACE_CH);
        push_comment();
        push_byte(LF_CH);
      end
      11: push_byte(CR_CH);
      default: push_byte(SPACE_CH);
    endcase
  endfunction

  function automatic void push_tok(input longint unsigned v);
    string s;
    bit    noisy;
    s     = $sformatf("%0d", v);
    noisy = ($urandom_range(0, 24) == 0);
    if ($urandom_range(0, 19) == 0) begin
      push_byte(DIGIT_LO);
      push_byte(DIGIT_LO);
    end
    foreach (s[i]) begin
      push_byte(s[i]);
      // letters are skipped without ending the token
      if (i == 0 && noisy) begin
        push_byte(CH_BITS'(8'h61 + $urandom_range(0, 25)));
      end
    end
    // comment right after the digits: token ends at the line end
    if ($urandom_range(0, 29) == 0) begin
      push_comment();
      push_byte(LF_CH);
    end
  endfunction

  task automatic build_stream();
    int unsigned     w;
    int unsigned     h;
    int unsigned     maxv;
    int unsigned     n_smp;
    int unsigned     pick;
    int unsigned     cut;
    longint unsigned area;
    longint unsigned smp;
    stream_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 4)) begin
        stream_q.push_back(CH_BITS'($urandom_range(11, 255)));
      end
    end else begin
      stream_q.push_back("P");
      stream_q.push_back("2");
    end
    stream_q.push_back(LF_CH);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(3, 20)) begin
        push_byte(CH_BITS'($urandom_range(0, 255)));
      end
      return;
    end
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    if (pick < 12) begin
      if ($urandom_range(0, 1)) begin
        w = 0;
      end else begin
        h = 0;
      end
    end else if (pick < 18) begin
      w = $urandom_range(1100, 65535);
      h = $urandom_range(1000, 65535);
    end else if (pick < 22) begin
      // right at the pixel limit, and one row past it
      w = 1024;
      h = $urandom_range(1024, 1025);
    end else if (pick < 26) begin
      w = $urandom_range(65536, 999999);
      h = 1;
    end else if (pick < 34) begin
      w = $urandom_range(7, 16);
      h = $urandom_range(1, 2);
    end
    maxv = ($urandom_range(0, 19) == 0) ? $urandom_range(65536, 999999) :
                                         $urandom_range(1, 65535);
    push_tok(w);
    push_sep();
    push_tok(h);
    push_sep();
    push_tok(maxv);
    area = longint'(w) * longint'(h);
    if (area > 0 && area <= 32) begin
      if ($urandom_range(0, 3) == 0) begin
        n_smp = $urandom_range(0, area);
      end else begin
        n_smp = 32'(area) + $urandom_range(0, 3);
      end
    end else begin
      n_smp = $urandom_range(2, 8);
    end
    for (int i = 0; i < n_smp; i++) begin
      push_sep();
      if ($urandom_range(0, 24) == 0) begin
        smp = 64'd9999999999;
      end else begin
        smp = $urandom_range(0, (maxv > 65535) ? 65535 : maxv);
      end
      push_tok(smp);
    end
    case ($urandom_range(0, 2))
      1: push_sep();
      2: begin
        push_byte(SPACE_CH);
        push_comment();
      end
      default: ;
    endcase
    if ($urandom_range(0, 99) < 6) begin
      cut = $urandom_range(1, stream_q.size());
      stream_q = stream_q[0:cut-1];
    end
  endtask

  initial begin
    int streams;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.ch           <= '0;
    in_chan.end_of_input <= 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // tab and cr delimiters, saturated max value, letter inside a token,
    // hash inside a token, excess sample flushed at end of input
    send_text("P\n2\t1\r7a0000 3#x\n4 5");
    // empty image: every sample dropped
    send_text("P\n0 3 1 8");
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 15 : (ph == 1) ? 69 : 0;
      rcv_idle = (ph == 0) ? 69 : (ph == 1) ? 15 : 0;
      streams  = 0;
      while (body_bytes < 600 * (ph + 1)) begin
        build_stream();
        // long hold-off while bytes keep coming
        if (streams == 2) begin
          hold_req = 200 + $urandom_range(0, 100);
        end
        send_stream();
        streams++;
        if (streams % 10 == 0) begin
          drain();
        end
      end
      drain();
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
